// ===== rtl/uart_set_color_command_parser_assert.svh =====
// assertion macros for the set color command parser
`ifndef UART_SET_COLOR_COMMAND_PARSER_ASSERT_SVH
`define UART_SET_COLOR_COMMAND_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UCP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ucp assertion failed");
`define UCP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ucp assertion failed");
`else
`define UCP_ASSERT(label, prop)
`define UCP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/ucp_pkg.sv =====
// shared constants, types and helper functions of the set color command parser
`timescale 1ns / 1ps

package ucp_pkg;

  localparam int LINE_CAP   = 32;
  localparam int CNT_W      = $clog2(LINE_CAP);
  localparam int CNT_MAX    = LINE_CAP - 1;
  localparam int PREFIX_LEN = 10;
  localparam int PFX_W      = 4;
  localparam int ACC_W      = 9;
  localparam int LEVEL_MAX  = 255;
  localparam int ACC_SAT    = 256;
  localparam int NUM_VALUES = 3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // "SET_COLOR="
  function automatic logic [7:0] prefix_char(input logic [PFX_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0: ch = 8'h53;
      4'd1: ch = 8'h45;
      4'd2: ch = 8'h54;
      4'd3: ch = 8'h5F;
      4'd4: ch = 8'h43;
      4'd5: ch = 8'h4F;
      4'd6: ch = 8'h4C;
      4'd7: ch = 8'h4F;
      4'd8: ch = 8'h52;
      4'd9: ch = 8'h3D;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/uart_set_color_command_parser.sv =====
// top level of the set color command parser
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid, in_ready, in_rx_byte
//   out     | output    | out_valid, out_ready, out_status, out_red, out_green, out_blue
//
// one byte per cycle while the result register is empty or being taken; a byte passes
// the input register, then the parse logic, and a line result for a CR or LF is
// registered in the result register, which sets the stall: a byte waits in the input register
// while an untaken result sits in the result register
// synchronous active-low reset clears the line state and both valid flags
`timescale 1ns / 1ps

module uart_set_color_command_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic             byte_vld;
  logic [7:0]       rx_byte_q;
  logic             slot_free;
  logic             fire;
  logic             res_vld;
  ucp_pkg::result_t res;

  assign fire = byte_vld && slot_free;

  ucp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (fire),
    .byte_vld   (byte_vld),
    .rx_byte_q  (rx_byte_q)
  );

  ucp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (rx_byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  ucp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_vld    (res_vld),
    .res        (res),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule

// ===== rtl/ucp_in_stage.sv =====
// input register holding one received byte ahead of the parser
`timescale 1ns / 1ps

module ucp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_vld,
  output logic [7:0] rx_byte_q
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       load;

  assign in_ready = !vld_r || take;
  assign load     = in_valid && in_ready;

  always_comb begin
    byte_nxt = load ? in_rx_byte : byte_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_vld  = vld_r;
  assign rx_byte_q = byte_r;

endmodule

// ===== rtl/ucp_parser.sv =====
// line state and per-byte parse logic, one byte per cycle while fire is high
`timescale 1ns / 1ps
`include "uart_set_color_command_parser_assert.svh"

module ucp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       rx_byte,
  output logic             res_vld,
  output ucp_pkg::result_t res
);

  logic [ucp_pkg::CNT_W-1:0] stored_cnt_r, stored_cnt_nxt;
  logic [ucp_pkg::PFX_W-1:0] pfx_pos_r, pfx_pos_nxt;
  logic [1:0]                num_idx_r, num_idx_nxt;
  logic [ucp_pkg::ACC_W-1:0] acc_r [ucp_pkg::NUM_VALUES];
  logic [ucp_pkg::ACC_W-1:0] acc_nxt [ucp_pkg::NUM_VALUES];
  logic                      digit_seen_r, digit_seen_nxt;
  logic                      format_bad_r, format_bad_nxt;
  logic                      prefix_bad_r, prefix_bad_nxt;
  logic                      numbers_done_r, numbers_done_nxt;
  logic                      content_end_r, content_end_nxt;

  logic                      is_eol;
  logic [1:0]                k;
  logic [11:0]               mac;
  logic [ucp_pkg::ACC_W-1:0] acc_step;
  logic                      over;

  assign is_eol = (rx_byte == ucp_pkg::CH_LF) || (rx_byte == ucp_pkg::CH_CR);
  assign k      = (num_idx_r > 2'd2) ? 2'd2 : num_idx_r;

  // multiply-by-ten and add of the current number with saturation
  assign mac = 12'(acc_r[k]) * 12'd10 + 12'(rx_byte[3:0]);
  assign acc_step = (mac > 12'(ucp_pkg::LEVEL_MAX)) ? ucp_pkg::ACC_W'(ucp_pkg::ACC_SAT)
                                                    : mac[ucp_pkg::ACC_W-1:0];

  assign over = (acc_r[0] > ucp_pkg::ACC_W'(ucp_pkg::LEVEL_MAX)) ||
                (acc_r[1] > ucp_pkg::ACC_W'(ucp_pkg::LEVEL_MAX)) ||
                (acc_r[2] > ucp_pkg::ACC_W'(ucp_pkg::LEVEL_MAX));

  always_comb begin
    stored_cnt_nxt   = stored_cnt_r;
    pfx_pos_nxt      = pfx_pos_r;
    num_idx_nxt      = num_idx_r;
    acc_nxt          = acc_r;
    digit_seen_nxt   = digit_seen_r;
    format_bad_nxt   = format_bad_r;
    prefix_bad_nxt   = prefix_bad_r;
    numbers_done_nxt = numbers_done_r;
    content_end_nxt  = content_end_r;
    res_vld          = 1'b0;
    res              = '0;
    res.status       = ucp_pkg::ST_OK;

    if (fire) begin
      if (is_eol) begin
        if ((pfx_pos_r != '0) || prefix_bad_r) begin
          res_vld = 1'b1;
          if (prefix_bad_r || (pfx_pos_r < ucp_pkg::PFX_W'(ucp_pkg::PREFIX_LEN))) begin
            res.status = ucp_pkg::ST_UNKNOWN;
          end else if (format_bad_r) begin
            res.status = ucp_pkg::ST_FORMAT;
          end else if (numbers_done_r || ((num_idx_r == 2'd2) && digit_seen_r)) begin
            if (over) begin
              res.status = ucp_pkg::ST_RANGE;
            end else begin
              res.red   = acc_r[0][7:0];
              res.green = acc_r[1][7:0];
              res.blue  = acc_r[2][7:0];
            end
          end else begin
            res.status = ucp_pkg::ST_FORMAT;
          end
        end
        // line end clears the line state
        stored_cnt_nxt   = '0;
        pfx_pos_nxt      = '0;
        num_idx_nxt      = '0;
        for (int i = 0; i < ucp_pkg::NUM_VALUES; i++) begin
          acc_nxt[i] = '0;
        end
        digit_seen_nxt   = 1'b0;
        format_bad_nxt   = 1'b0;
        prefix_bad_nxt   = 1'b0;
        numbers_done_nxt = 1'b0;
        content_end_nxt  = 1'b0;
      end else if (stored_cnt_r < ucp_pkg::CNT_W'(ucp_pkg::CNT_MAX)) begin
        stored_cnt_nxt = stored_cnt_r + 1'b1;
        if (!content_end_r) begin
          if (rx_byte == ucp_pkg::CH_NUL) begin
            content_end_nxt = 1'b1;
          end else if (!prefix_bad_r) begin
            if (pfx_pos_r < ucp_pkg::PFX_W'(ucp_pkg::PREFIX_LEN)) begin
              if (rx_byte == ucp_pkg::prefix_char(pfx_pos_r)) begin
                pfx_pos_nxt = pfx_pos_r + 1'b1;
              end else begin
                prefix_bad_nxt = 1'b1;
              end
            end else if (!format_bad_r && !numbers_done_r) begin
              if (!digit_seen_r) begin
                if (ucp_pkg::is_digit(rx_byte)) begin
                  acc_nxt[k]     = ucp_pkg::ACC_W'(rx_byte[3:0]);
                  digit_seen_nxt = 1'b1;
                end else if (!ucp_pkg::is_blank(rx_byte)) begin
                  format_bad_nxt = 1'b1;
                end
              end else if (ucp_pkg::is_digit(rx_byte)) begin
                acc_nxt[k] = acc_step;
              end else if ((k < 2'd2) && (rx_byte == ucp_pkg::CH_COMMA)) begin
                num_idx_nxt    = k + 2'd1;
                digit_seen_nxt = 1'b0;
              end else if (k == 2'd2) begin
                numbers_done_nxt = 1'b1;
              end else begin
                format_bad_nxt = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_cnt_r   <= '0;
      pfx_pos_r      <= '0;
      num_idx_r      <= '0;
      for (int i = 0; i < ucp_pkg::NUM_VALUES; i++) begin
        acc_r[i] <= '0;
      end
      digit_seen_r   <= 1'b0;
      format_bad_r   <= 1'b0;
      prefix_bad_r   <= 1'b0;
      numbers_done_r <= 1'b0;
      content_end_r  <= 1'b0;
    end else begin
      stored_cnt_r   <= stored_cnt_nxt;
      pfx_pos_r      <= pfx_pos_nxt;
      num_idx_r      <= num_idx_nxt;
      acc_r          <= acc_nxt;
      digit_seen_r   <= digit_seen_nxt;
      format_bad_r   <= format_bad_nxt;
      prefix_bad_r   <= prefix_bad_nxt;
      numbers_done_r <= numbers_done_nxt;
      content_end_r  <= content_end_nxt;
    end
  end

  `UCP_ASSERT(a_pfx_range, pfx_pos_r <= ucp_pkg::PFX_W'(ucp_pkg::PREFIX_LEN))
  `UCP_ASSERT(a_cnt_range, stored_cnt_r <= ucp_pkg::CNT_W'(ucp_pkg::CNT_MAX))
  `UCP_ASSERT(a_idx_range, num_idx_r != 2'd3)
  `UCP_ASSERT(a_res_on_eol, res_vld |-> (fire && is_eol))
  `UCP_ASSERT(a_eol_clears, (fire && is_eol) |=> ((stored_cnt_r == '0) && (pfx_pos_r == '0)))
  `UCP_ASSERT(a_num_after_pfx, (format_bad_r || numbers_done_r) |-> (pfx_pos_r == ucp_pkg::PFX_W'(ucp_pkg::PREFIX_LEN)))

endmodule

// ===== rtl/ucp_out_stage.sv =====
// result register driving the output channel
`timescale 1ns / 1ps

module ucp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_vld,
  input  ucp_pkg::result_t res,
  output logic             slot_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue
);

  logic             vld_r, vld_nxt;
  ucp_pkg::result_t res_r, res_nxt;

  assign slot_free = !vld_r || out_ready;

  always_comb begin
    res_nxt = res_vld ? res : res_r;
    if (res_vld) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid  = vld_r;
  assign out_status = res_r.status;
  assign out_red    = res_r.red;
  assign out_green  = res_r.green;
  assign out_blue   = res_r.blue;

endmodule

// ===== sim/tb.sv =====
// testbench for the set color command parser: directed and random lines against a line predictor
`timescale 1ns / 1ps

module tb;

  localparam int    CYCLE_LIMIT = 300000;
  localparam int    DRAIN_WAIT  = 20;
  localparam string CMD_WORD    = "SET_COLOR=";

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // line parse state of the predictor
  int         line_kept;
  int         pfx_matched;
  int         num_sel;
  int         level_acc[3];
  bit         have_digit;
  bit         fmt_err;
  bit         pfx_err;
  bit         nums_finished;
  bit         nul_seen;

  ucp_pkg::result_t pending_colors[$];
  ucp_pkg::result_t want;
  int         fail_count;
  int         cycle_count;
  int         bytes_sent;
  int         send_idle_pct;
  int         recv_stall_pct;

  uart_set_color_command_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void clear_line();
    line_kept     = 0;
    pfx_matched   = 0;
    num_sel       = 0;
    level_acc     = '{0, 0, 0};
    have_digit    = 1'b0;
    fmt_err       = 1'b0;
    pfx_err       = 1'b0;
    nums_finished = 1'b0;
    nul_seen      = 1'b0;
  endfunction

  function automatic void parse_number_byte(input logic [7:0] c);
    bit blank;
    bit digit;
    int v;
    blank = (c == ucp_pkg::CH_SPACE) || (c == ucp_pkg::CH_TAB) ||
            (c == ucp_pkg::CH_VT) || (c == ucp_pkg::CH_FF);
    digit = (c >= ucp_pkg::CH_ZERO) && (c <= ucp_pkg::CH_NINE);
    if (!have_digit) begin
      if (digit) begin
        level_acc[num_sel] = c - ucp_pkg::CH_ZERO;
        have_digit = 1'b1;
      end else if (!blank) begin
        fmt_err = 1'b1;
      end
    end else if (digit) begin
      v = level_acc[num_sel] * 10 + (c - ucp_pkg::CH_ZERO);
      level_acc[num_sel] = (v > ucp_pkg::LEVEL_MAX) ? ucp_pkg::ACC_SAT : v;
    end else if (num_sel < 2 && c == ucp_pkg::CH_COMMA) begin
      num_sel++;
      have_digit = 1'b0;
    end else if (num_sel == 2) begin
      nums_finished = 1'b1;
    end else begin
      fmt_err = 1'b1;
    end
  endfunction

  // updates the line state for one byte and queues the line result at a line end
  function automatic void predict_line_byte(input logic [7:0] c);
    ucp_pkg::result_t r;
    logic [7:0] ch;
    if (c == ucp_pkg::CH_LF || c == ucp_pkg::CH_CR) begin
      if (pfx_matched != 0 || pfx_err) begin
        r = '0;
        if (pfx_err || pfx_matched < ucp_pkg::PREFIX_LEN) begin
          r.status = ucp_pkg::ST_UNKNOWN;
        end else if (fmt_err) begin
          r.status = ucp_pkg::ST_FORMAT;
        end else if (nums_finished || (num_sel == 2 && have_digit)) begin
          if (level_acc[0] > ucp_pkg::LEVEL_MAX || level_acc[1] > ucp_pkg::LEVEL_MAX ||
              level_acc[2] > ucp_pkg::LEVEL_MAX) begin
            r.status = ucp_pkg::ST_RANGE;
          end else begin
            r.status = ucp_pkg::ST_OK;
            r.red    = level_acc[0][7:0];
            r.green  = level_acc[1][7:0];
            r.blue   = level_acc[2][7:0];
          end
        end else begin
          r.status = ucp_pkg::ST_FORMAT;
        end
        pending_colors.push_back(r);
      end
      clear_line();
    end else if (line_kept < ucp_pkg::CNT_MAX) begin
      line_kept++;
      if (nul_seen) begin
      end else if (c == ucp_pkg::CH_NUL) begin
        nul_seen = 1'b1;
      end else if (pfx_err) begin
      end else if (pfx_matched < ucp_pkg::PREFIX_LEN) begin
        ch = CMD_WORD[pfx_matched];
        if (c == ch) pfx_matched++;
        else pfx_err = 1'b1;
      end else if (!fmt_err && !nums_finished) begin
        parse_number_byte(c);
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_line_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic test_valid_colors();
    send_text("SET_COLOR=0,0,0\r");
    send_text("SET_COLOR=255,128,7\n");
    send_text("SET_COLOR=");
    send_byte(ucp_pkg::CH_SPACE);
    send_byte(ucp_pkg::CH_TAB);
    send_text("1,");
    send_byte(ucp_pkg::CH_VT);
    send_text("022,");
    send_byte(ucp_pkg::CH_FF);
    send_text("255 tail\r");
  endtask

  task automatic test_range_errors();
    send_text("SET_COLOR=256,0,0\r");
    send_text("SET_COLOR=1,2,99999\n");
    send_text("SET_COLOR=300,x,1\r");
  endtask

  task automatic test_format_errors();
    send_text("SET_COLOR=+1,2,3\r");
    send_text("SET_COLOR=1,-2,3\n");
    send_text("SET_COLOR=1,2\r");
    send_text("SET_COLOR=1,,3\n");
    send_text("SET_COLOR=\r");
  endtask

  task automatic test_unknown_commands();
    send_text("SET_COLO\r");
    send_text("SET-COLOR=1,2,3\n");
    send_text("X\r");
  endtask

  task automatic test_line_handling();
    send_text("\r\n");
    send_byte(ucp_pkg::CH_NUL);
    send_text("ABC\n");
    send_text("SET_COLOR=1,2,3");
    send_byte(ucp_pkg::CH_NUL);
    send_text("junk\r");
    send_text("SET_COLOR=1,2,                    5\r");
    send_text("SET_COLOR=10,20,30 and a long tail of text\n");
    send_byte(8'hFF);
    send_text("\r");
  endtask

  task automatic send_random_line();
    logic [7:0] text[$];
    int         pick;
    int         val;
    int         pad;
    int         pos;
    string      digits;
    pick = $urandom_range(99);
    if (pick < 70) begin
      for (int i = 0; i < ucp_pkg::PREFIX_LEN; i++) text.push_back(CMD_WORD[i]);
      for (int n = 0; n < ucp_pkg::NUM_VALUES; n++) begin
        pad = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, ($urandom_range(4) == 0) ? 12 : 2);
        repeat (pad) begin
          case ($urandom_range(3))
            0: text.push_back(ucp_pkg::CH_SPACE);
            1: text.push_back(ucp_pkg::CH_TAB);
            2: text.push_back(ucp_pkg::CH_VT);
            default: text.push_back(ucp_pkg::CH_FF);
          endcase
        end
        val = $urandom_range(99);
        if (val < 75) val = $urandom_range(255);
        else if (val < 90) val = $urandom_range(999, 256);
        else val = $urandom_range(99999);
        digits = $sformatf("%0d", val);
        if ($urandom_range(9) == 0) digits = {"00", digits};
        for (int i = 0; i < digits.len(); i++) text.push_back(digits[i]);
        if (n < ucp_pkg::NUM_VALUES - 1) text.push_back(ucp_pkg::CH_COMMA);
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(33, 126)));
      end
      if ($urandom_range(99) < 25) begin
        pos = $urandom_range(text.size() - 1);
        case ($urandom_range(3))
          0: text[pos] = 8'($urandom_range(255));
          1: text.insert(pos, $urandom_range(1) ? "+" : "-");
          2: text.delete(pos);
          default: text.insert(pos, ucp_pkg::CH_NUL);
        endcase
      end
    end else if (pick < 85) begin
      repeat ($urandom_range(40)) text.push_back(8'($urandom_range(255)));
    end else begin
      pos = $urandom_range(ucp_pkg::PREFIX_LEN);
      for (int i = 0; i < pos; i++) text.push_back(CMD_WORD[i]);
      repeat ($urandom_range(5)) text.push_back(8'($urandom_range(255)));
    end
    text.push_back($urandom_range(1) ? ucp_pkg::CH_CR : ucp_pkg::CH_LF);
    if ($urandom_range(7) == 0) text.push_back($urandom_range(1) ? ucp_pkg::CH_CR : ucp_pkg::CH_LF);
    foreach (text[i]) send_byte(text[i]);
  endtask

  task automatic test_random_lines(input int idle_pct, input int stall_pct, input int budget);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < budget) send_random_line();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result: status %0d", out_status);
        fail_count++;
      end else begin
        want = pending_colors.pop_front();
        if (out_status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_red != want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_red);
          fail_count++;
        end
        if (out_green != want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_green);
          fail_count++;
        end
        if (out_blue != want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_blue);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = '0;
    out_ready      = 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    bytes_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    clear_line();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_valid_colors();
    test_range_errors();
    test_format_errors();
    test_unknown_commands();
    test_line_handling();
    test_random_lines(0, 0, 70);
    test_random_lines(62, 0, 70);
    test_random_lines(0, 62, 70);
    test_random_lines(26, 26, 70);
    in_valid <= 1'b0;

    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
